>>> hw/rtl/apv_deconvolution_peak_finder_core_assert.svh
// Assertion macros used by the checker file of the peak finder.
// Each macro expands to one labelled concurrent assertion, clocked on the
// rising edge and switched off while reset is held.
`ifndef APV_DECONVOLUTION_PEAK_FINDER_CORE_ASSERT_SVH
`define APV_DECONVOLUTION_PEAK_FINDER_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define APVDPF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define APVDPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/apvdpf_pkg.sv
package apvdpf_pkg;

    // Result status codes, in the order in which the reasons are tested.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OFF_TRACK  = 2'd1,
        ST_BAD_PEAK   = 2'd2,
        ST_BAD_SHAPE  = 2'd3
    } t_status;

    // Register word indexes on the configuration port.
    localparam logic [2:0] REG_WEIGHT_NOW   = 3'd0;
    localparam logic [2:0] REG_WEIGHT_PREV  = 3'd1;
    localparam logic [2:0] REG_WEIGHT_PREV2 = 3'd2;
    localparam logic [2:0] REG_LOW_THRESH   = 3'd3;
    localparam logic [2:0] REG_HIGH_THRESH  = 3'd4;

    // Register values after reset.
    localparam logic signed [15:0] RST_WEIGHT_NOW   = 16'sd5397;
    localparam logic signed [15:0] RST_WEIGHT_PREV  = -16'sd7032;
    localparam logic signed [15:0] RST_WEIGHT_PREV2 = 16'sd2290;
    localparam logic signed [15:0] RST_LOW_THRESH   = 16'sd50;
    localparam logic signed [15:0] RST_HIGH_THRESH  = 16'sd100;

    // A candidate maximum: deconvolved value and its sample index.
    typedef struct packed {
        logic signed [15:0] value;
        logic [2:0]         index;
    } t_peak;

    // Stage enables of one deconvolution lane.
    typedef struct packed {
        logic st_mul;
        logic st_sum;
    } t_lane_en;

    // Stage enables of the merging stage.
    typedef struct packed {
        logic st_pair;
        logic st_best;
        logic st_out;
    } t_merge_en;

    // Later candidate wins only when strictly larger, so ties keep the first.
    function automatic t_peak pick_peak(input t_peak a, input t_peak b);
        return (b.value > a.value) ? b : a;
    endfunction

endpackage

>>> hw/rtl/apv_deconvolution_peak_finder_core.sv
// APV25 strip-hit deconvolution peak finder. One hit (six samples, on-track
// flag, peak hint) is taken in every clock cycle unless the input is stalled,
// and its single result passes through the registers of the four deconvolution
// lanes (product register, then sum, round and saturate) and then the merging
// stage (pairwise maximum, final maximum, thresholds and output register).
// Sustained rate is one hit per cycle while the output is not stalled, set by
// the three fully pipelined multipliers of each lane. When the output is
// stalled, stages fill up behind it and any bubbles are squeezed out before
// the input is stalled. Registers sit on the APB port at byte addresses 0
// (weight_now), 4 (weight_prev), 8 (weight_prev2), 12 (low threshold) and 16
// (high threshold); write them only while no hit is in flight.
module apv_deconvolution_peak_finder_core #(
    parameter int SAMPLE_BITS      = 13,
    parameter int WEIGHT_FRAC_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_on_track,
    input  logic [2:0]                    i_peak_hint,
    input  logic signed [SAMPLE_BITS-1:0] i_sample0,
    input  logic signed [SAMPLE_BITS-1:0] i_sample1,
    input  logic signed [SAMPLE_BITS-1:0] i_sample2,
    input  logic signed [SAMPLE_BITS-1:0] i_sample3,
    input  logic signed [SAMPLE_BITS-1:0] i_sample4,
    input  logic signed [SAMPLE_BITS-1:0] i_sample5,
    // Output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic signed [15:0]            o_deconv2,
    output logic signed [15:0]            o_deconv3,
    output logic signed [15:0]            o_deconv4,
    output logic signed [15:0]            o_deconv5,
    output logic [2:0]                    o_peak_index,
    output logic signed [15:0]            o_peak_value,
    output logic                          o_over_low,
    output logic                          o_over_high
);
    import apvdpf_pkg::*;

    localparam int NSTG = 5;

    logic signed [15:0]            r_weight_now;
    logic signed [15:0]            r_weight_prev;
    logic signed [15:0]            r_weight_prev2;
    logic signed [15:0]            r_low_thresh;
    logic signed [15:0]            r_high_thresh;
    logic                          n_wr;
    logic [2:0]                    n_reg_idx;

    logic [NSTG-1:0]               r_vld;
    logic [NSTG-1:0]               n_adv;
    logic                          n_in_acc;

    logic signed [SAMPLE_BITS-1:0] n_s [6];
    logic [4:0]                    n_up;
    logic [4:0]                    n_dn;
    t_status                       n_status;
    t_status                       r_status0;
    t_status                       r_status1;
    logic signed [15:0]            n_deconv [4];
    t_lane_en                      n_lane_en;
    t_merge_en                     n_merge_en;

    // Register file: writes in the access phase, reads return the value.
    assign pready    = 1'b1;
    assign n_reg_idx = paddr[4:2];
    assign n_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_now   <= RST_WEIGHT_NOW;
            r_weight_prev  <= RST_WEIGHT_PREV;
            r_weight_prev2 <= RST_WEIGHT_PREV2;
            r_low_thresh   <= RST_LOW_THRESH;
            r_high_thresh  <= RST_HIGH_THRESH;
        end else if (n_wr) begin
            unique case (n_reg_idx)
                REG_WEIGHT_NOW:   r_weight_now   <= pwdata[15:0];
                REG_WEIGHT_PREV:  r_weight_prev  <= pwdata[15:0];
                REG_WEIGHT_PREV2: r_weight_prev2 <= pwdata[15:0];
                REG_LOW_THRESH:   r_low_thresh   <= pwdata[15:0];
                REG_HIGH_THRESH:  r_high_thresh  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (n_reg_idx)
            REG_WEIGHT_NOW:   prdata = {16'd0, r_weight_now};
            REG_WEIGHT_PREV:  prdata = {16'd0, r_weight_prev};
            REG_WEIGHT_PREV2: prdata = {16'd0, r_weight_prev2};
            REG_LOW_THRESH:   prdata = {16'd0, r_low_thresh};
            REG_HIGH_THRESH:  prdata = {16'd0, r_high_thresh};
            default:          prdata = 32'd0;
        endcase
    end

    // Stage enables: a stage moves when it is empty or the next one moves.
    always_comb begin
        n_adv[NSTG-1] = !r_vld[NSTG-1] || !i_out_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            n_adv[k] = !r_vld[k] || n_adv[k+1];
        end
    end

    assign o_in_stall = !n_adv[0];
    assign n_in_acc   = i_in_valid && n_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_adv[0]) begin
                r_vld[0] <= n_in_acc;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (n_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_out_valid = r_vld[NSTG-1];

    // Hit qualification: track flag, peak position, then pulse shape.
    assign n_s[0] = i_sample0;
    assign n_s[1] = i_sample1;
    assign n_s[2] = i_sample2;
    assign n_s[3] = i_sample3;
    assign n_s[4] = i_sample4;
    assign n_s[5] = i_sample5;

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            n_up[k] = n_s[k] < n_s[k+1];
            n_dn[k] = n_s[k] > n_s[k+1];
        end
        if (!i_on_track) begin
            n_status = ST_OFF_TRACK;
        end else if (i_peak_hint == 3'd2) begin
            n_status = (n_up[0] && n_up[1] && n_dn[2] && n_dn[3] && n_dn[4])
                     ? ST_OK : ST_BAD_SHAPE;
        end else if (i_peak_hint == 3'd3) begin
            n_status = (n_up[0] && n_up[1] && n_up[2] && n_dn[3] && n_dn[4])
                     ? ST_OK : ST_BAD_SHAPE;
        end else begin
            n_status = ST_BAD_PEAK;
        end
    end

    // Status travels beside the lanes' two stages.
    always_ff @(posedge i_clk) begin
        if (n_adv[0]) begin
            r_status0 <= n_status;
        end
        if (n_adv[1]) begin
            r_status1 <= r_status0;
        end
    end

    // Four deconvolution lanes, one per output sample 2 to 5.
    assign n_lane_en = '{st_mul: n_adv[0], st_sum: n_adv[1]};

    for (genvar g = 0; g < 4; g++) begin : g_lane
        apvdpf_lane #(
            .SAMPLE_BITS      (SAMPLE_BITS),
            .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
        ) u_lane (
            .i_clk          (i_clk),
            .i_en           (n_lane_en),
            .i_weight_now   (r_weight_now),
            .i_weight_prev  (r_weight_prev),
            .i_weight_prev2 (r_weight_prev2),
            .i_s_now        (n_s[g+2]),
            .i_s_prev       (n_s[g+1]),
            .i_s_prev2      (n_s[g]),
            .o_deconv       (n_deconv[g])
        );
    end

    // Maximum search, thresholds and output register.
    assign n_merge_en = '{st_pair: n_adv[2], st_best: n_adv[3], st_out: n_adv[4]};

    apvdpf_merge u_merge (
        .i_clk            (i_clk),
        .i_en             (n_merge_en),
        .i_status         (r_status1),
        .i_deconv2        (n_deconv[0]),
        .i_deconv3        (n_deconv[1]),
        .i_deconv4        (n_deconv[2]),
        .i_deconv5        (n_deconv[3]),
        .i_low_threshold  (r_low_thresh),
        .i_high_threshold (r_high_thresh),
        .o_status         (o_status),
        .o_deconv2        (o_deconv2),
        .o_deconv3        (o_deconv3),
        .o_deconv4        (o_deconv4),
        .o_deconv5        (o_deconv5),
        .o_peak_index     (o_peak_index),
        .o_peak_value     (o_peak_value),
        .o_over_low       (o_over_low),
        .o_over_high      (o_over_high)
    );

endmodule

>>> hw/rtl/apvdpf_lane.sv
module apvdpf_lane #(
    parameter int SAMPLE_BITS      = 13,
    parameter int WEIGHT_FRAC_BITS = 12
) (
    input  logic                          i_clk,
    input  apvdpf_pkg::t_lane_en          i_en,
    input  logic signed [15:0]            i_weight_now,
    input  logic signed [15:0]            i_weight_prev,
    input  logic signed [15:0]            i_weight_prev2,
    input  logic signed [SAMPLE_BITS-1:0] i_s_now,
    input  logic signed [SAMPLE_BITS-1:0] i_s_prev,
    input  logic signed [SAMPLE_BITS-1:0] i_s_prev2,
    output logic signed [15:0]            o_deconv
);
    import apvdpf_pkg::*;

    localparam int PW = SAMPLE_BITS + 16;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (WEIGHT_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] DMAX = SW'(32767);
    localparam logic signed [SW-1:0] DMIN = SW'(-32768);

    logic signed [PW-1:0] r_p_now;
    logic signed [PW-1:0] r_p_prev;
    logic signed [PW-1:0] r_p_prev2;
    logic signed [SW-1:0] n_acc;
    logic signed [SW-1:0] n_round;
    logic signed [15:0]   n_deconv;
    logic signed [15:0]   r_deconv;

    // The three tap products, one multiplier each.
    always_ff @(posedge i_clk) begin
        if (i_en.st_mul) begin
            r_p_now   <= PW'(i_weight_now) * PW'(i_s_now);
            r_p_prev  <= PW'(i_weight_prev) * PW'(i_s_prev);
            r_p_prev2 <= PW'(i_weight_prev2) * PW'(i_s_prev2);
        end
    end

    // Exact sum, round half up, then saturate to 16 bits.
    always_comb begin
        n_acc   = SW'(r_p_now) + SW'(r_p_prev) + SW'(r_p_prev2) + HALF;
        n_round = n_acc >>> WEIGHT_FRAC_BITS;
        if (n_round > DMAX) begin
            n_deconv = 16'sh7fff;
        end else if (n_round < DMIN) begin
            n_deconv = 16'sh8000;
        end else begin
            n_deconv = n_round[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.st_sum) begin
            r_deconv <= n_deconv;
        end
    end

    assign o_deconv = r_deconv;

endmodule

>>> hw/rtl/apvdpf_merge.sv
module apvdpf_merge (
    input  logic                  i_clk,
    input  apvdpf_pkg::t_merge_en i_en,
    input  apvdpf_pkg::t_status   i_status,
    input  logic signed [15:0]    i_deconv2,
    input  logic signed [15:0]    i_deconv3,
    input  logic signed [15:0]    i_deconv4,
    input  logic signed [15:0]    i_deconv5,
    input  logic signed [15:0]    i_low_threshold,
    input  logic signed [15:0]    i_high_threshold,
    output logic [1:0]            o_status,
    output logic signed [15:0]    o_deconv2,
    output logic signed [15:0]    o_deconv3,
    output logic signed [15:0]    o_deconv4,
    output logic signed [15:0]    o_deconv5,
    output logic [2:0]            o_peak_index,
    output logic signed [15:0]    o_peak_value,
    output logic                  o_over_low,
    output logic                  o_over_high
);
    import apvdpf_pkg::*;

    t_peak              r_pa;
    t_peak              r_pb;
    t_peak              r_pc;
    t_peak              r_best;
    t_status            r_status_a;
    t_status            r_status_b;
    logic signed [15:0] r_d_a [4];
    logic signed [15:0] r_d_b [4];
    t_status            r_status_o;
    logic signed [15:0] r_d_o [4];
    t_peak              r_peak_o;
    logic               r_low_o;
    logic               r_high_o;
    logic               n_ok;

    // First level: the zero samples against sample 2, samples 3 and 4 paired.
    always_ff @(posedge i_clk) begin
        if (i_en.st_pair) begin
            r_pa       <= pick_peak(t_peak'{value: 16'sd0, index: 3'd0},
                                    t_peak'{value: i_deconv2, index: 3'd2});
            r_pb       <= pick_peak(t_peak'{value: i_deconv3, index: 3'd3},
                                    t_peak'{value: i_deconv4, index: 3'd4});
            r_pc       <= t_peak'{value: i_deconv5, index: 3'd5};
            r_status_a <= i_status;
            r_d_a[0]   <= i_deconv2;
            r_d_a[1]   <= i_deconv3;
            r_d_a[2]   <= i_deconv4;
            r_d_a[3]   <= i_deconv5;
        end
    end

    // Second level: the overall maximum, lowest index kept on a tie.
    always_ff @(posedge i_clk) begin
        if (i_en.st_best) begin
            r_best     <= pick_peak(pick_peak(r_pa, r_pb), r_pc);
            r_status_b <= r_status_a;
            r_d_b      <= r_d_a;
        end
    end

    assign n_ok = (r_status_b == ST_OK);

    // Output register: threshold flags, and every field but the status cleared on a reject.
    always_ff @(posedge i_clk) begin
        if (i_en.st_out) begin
            r_status_o <= r_status_b;
            for (int k = 0; k < 4; k++) begin
                r_d_o[k] <= n_ok ? r_d_b[k] : 16'sd0;
            end
            r_peak_o <= n_ok ? r_best : t_peak'{value: 16'sd0, index: 3'd0};
            r_low_o  <= n_ok && (r_best.value > i_low_threshold);
            r_high_o <= n_ok && (r_best.value > i_high_threshold);
        end
    end

    assign o_status     = r_status_o;
    assign o_deconv2    = r_d_o[0];
    assign o_deconv3    = r_d_o[1];
    assign o_deconv4    = r_d_o[2];
    assign o_deconv5    = r_d_o[3];
    assign o_peak_index = r_peak_o.index;
    assign o_peak_value = r_peak_o.value;
    assign o_over_low   = r_low_o;
    assign o_over_high  = r_high_o;

endmodule

>>> hw/rtl/apvdpf_checker.sv
`include "apv_deconvolution_peak_finder_core_assert.svh"

module apvdpf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_status,
    input logic signed [15:0] o_deconv2,
    input logic signed [15:0] o_deconv3,
    input logic signed [15:0] o_deconv4,
    input logic signed [15:0] o_deconv5,
    input logic [2:0]         o_peak_index,
    input logic signed [15:0] o_peak_value,
    input logic               o_over_low,
    input logic               o_over_high
);
    import apvdpf_pkg::*;

    // A rejected hit carries nothing but its reason.
    `APVDPF_ASSERT_NOW(a_reject_clear, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, o_deconv2 == 16'sd0 && o_deconv3 == 16'sd0 && o_deconv4 == 16'sd0 && o_deconv5 == 16'sd0 && o_peak_index == 3'd0 && o_peak_value == 16'sd0 && !o_over_low && !o_over_high, "rejected hit with non-zero result fields")

    // The peak index names a sample that can hold the maximum.
    `APVDPF_ASSERT_NOW(a_peak_index_range, i_clk, i_rst_n, o_out_valid, o_peak_index == 3'd0 || o_peak_index == 3'd2 || o_peak_index == 3'd3 || o_peak_index == 3'd4 || o_peak_index == 3'd5, "peak index outside the possible positions")

    // For an accepted hit, the peak value is the deconvolved sample at the peak index.
    `APVDPF_ASSERT_NOW(a_peak_matches, i_clk, i_rst_n, o_out_valid && o_status == ST_OK, (o_peak_index == 3'd0 && o_peak_value == 16'sd0) || (o_peak_index == 3'd2 && o_peak_value == o_deconv2) || (o_peak_index == 3'd3 && o_peak_value == o_deconv3) || (o_peak_index == 3'd4 && o_peak_value == o_deconv4) || (o_peak_index == 3'd5 && o_peak_value == o_deconv5), "peak value does not match the sample at its index")

    // A stalled result stays put.
    `APVDPF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_peak_value) && $stable(o_peak_index), "stalled result changed")

endmodule

bind apv_deconvolution_peak_finder_core apvdpf_checker u_checker (.*);
